[src/audio_matrix_mixer_macros.svh]
// Assertion macros shared by the mixer RTL
`ifndef AUDIO_MATRIX_MIXER_MACROS_SVH
`define AUDIO_MATRIX_MIXER_MACROS_SVH

// Same-cycle implication, checked on aclk, off during reset
`define AMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk, off during reset
`define AMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/mmx_pkg.sv]
// Types and constants of the audio matrix mixer
`timescale 1ns / 1ps
package mmx_pkg;

    localparam int IN_CHANNELS  = 4;
    localparam int OUT_CHANNELS = 4;

    // field slots on the ports stay fixed at four
    localparam int NUM_IN    = 4;
    localparam int NUM_OUT   = 4;
    localparam int SAMPLE_W  = 24;
    localparam int GAIN_W    = 16;
    localparam int ROW_W     = NUM_IN * GAIN_W;
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W    = SAMPLE_W + GAIN_W;
    localparam int ACC_W     = PROD_W + 2;
    localparam int FRAC_DROP = 12;
    localparam int RND_W     = ACC_W - FRAC_DROP;
    localparam int DATA_W    = NUM_OUT * SAMPLE_W;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [GAIN_W-1:0]   gain_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic signed [RND_W-1:0]    rnd_t;
    typedef logic [ROW_W-1:0]           row_t;

    typedef sample_t [NUM_IN-1:0]  frame_t;
    typedef gain_t   [NUM_OUT-1:0] gain_col_t;
    typedef acc_t    [NUM_OUT-1:0] acc_row_t;
    typedef sample_t [NUM_OUT-1:0] mix_t;

    localparam sample_t SAT_MAX = 24'sh7FFFFF;
    localparam sample_t SAT_MIN = 24'sh800000;
    localparam acc_t    RND_BIAS = acc_t'(2048);

endpackage

[src/mmx_cell.sv]
// One multiply-accumulate cell of the mixing chain (one input channel)
`timescale 1ns / 1ps
`include "audio_matrix_mixer_macros.svh"
module mmx_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               up_valid,
    output logic               up_ready,
    input  mmx_pkg::frame_t    up_frame,
    input  mmx_pkg::acc_row_t  up_acc,
    input  mmx_pkg::sample_t   tap_sample,
    input  mmx_pkg::gain_col_t tap_gains,
    output logic               dn_valid,
    input  logic               dn_ready,
    output mmx_pkg::frame_t    dn_frame,
    output mmx_pkg::acc_row_t  dn_acc
);

    logic                             valid_reg;
    logic                             valid_next;
    mmx_pkg::frame_t                  frame_reg;
    mmx_pkg::acc_row_t                acc_reg;
    mmx_pkg::acc_row_t                acc_next;
    logic signed [mmx_pkg::PROD_W-1:0] prod [mmx_pkg::NUM_OUT];

    assign up_ready = !valid_reg || dn_ready;

    always_comb begin
        for (int m = 0; m < mmx_pkg::NUM_OUT; m++) begin
            prod[m]     = $signed(tap_sample) * $signed(tap_gains[m]);
            acc_next[m] = up_acc[m] + mmx_pkg::ACC_W'(prod[m]);
        end
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            frame_reg <= up_frame;
            acc_reg   <= acc_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_frame = frame_reg;
    assign dn_acc   = acc_reg;

    `AMM_ASSERT_NEXT(a_cell_hold, valid_reg && !dn_ready, valid_reg && $stable(acc_reg), "sum lost")
    `AMM_ASSERT_NEXT(a_cell_load, up_valid && up_ready, valid_reg, "request not taken")
    `AMM_ASSERT_NOW(a_cell_ready, !valid_reg, up_ready, "empty cell refused a request")

endmodule

[src/mmx_sat.sv]
// Rounding, saturation and output register of the mixer
`timescale 1ns / 1ps
`include "audio_matrix_mixer_macros.svh"
module mmx_sat (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        up_valid,
    output logic                        up_ready,
    input  mmx_pkg::acc_row_t           up_acc,
    output logic                        dn_valid,
    input  logic                        dn_ready,
    output mmx_pkg::mix_t               dn_mix,
    output logic [mmx_pkg::NUM_OUT-1:0] dn_clip
);

    logic                        valid_reg;
    logic                        valid_next;
    mmx_pkg::mix_t               mix_reg;
    mmx_pkg::mix_t               mix_next;
    logic [mmx_pkg::NUM_OUT-1:0] clip_reg;
    logic [mmx_pkg::NUM_OUT-1:0] clip_next;
    mmx_pkg::acc_t               biased [mmx_pkg::NUM_OUT];
    mmx_pkg::rnd_t               rnd [mmx_pkg::NUM_OUT];

    assign up_ready = !valid_reg || dn_ready;

    // round half up to Q1.23, then clamp; unused outputs carry zero gains
    always_comb begin
        for (int m = 0; m < mmx_pkg::NUM_OUT; m++) begin
            biased[m] = up_acc[m] + mmx_pkg::RND_BIAS;
            rnd[m]    = biased[m][mmx_pkg::ACC_W-1:mmx_pkg::FRAC_DROP];
            if (rnd[m] > mmx_pkg::rnd_t'(mmx_pkg::SAT_MAX)) begin
                mix_next[m]  = mmx_pkg::SAT_MAX;
                clip_next[m] = 1'b1;
            end else if (rnd[m] < mmx_pkg::rnd_t'(mmx_pkg::SAT_MIN)) begin
                mix_next[m]  = mmx_pkg::SAT_MIN;
                clip_next[m] = 1'b1;
            end else begin
                mix_next[m]  = rnd[m][mmx_pkg::SAMPLE_W-1:0];
                clip_next[m] = 1'b0;
            end
        end
        valid_next = up_ready ? up_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (up_valid && up_ready) begin
            mix_reg  <= mix_next;
            clip_reg <= clip_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_mix   = mix_reg;
    assign dn_clip  = clip_reg;

    `AMM_ASSERT_NEXT(a_sat_load, up_valid && up_ready, valid_reg, "accepted sum did not reach output")

    for (genvar m = 0; m < mmx_pkg::NUM_OUT; m++) begin : g_chk
        `AMM_ASSERT_NOW(a_clip_rail, valid_reg && clip_reg[m], mix_reg[m] == mmx_pkg::SAT_MAX || mix_reg[m] == mmx_pkg::SAT_MIN, "clip flag without rail value")
    end

endmodule

[src/audio_matrix_mixer.sv]
// Top level of the four-by-four audio matrix mixer
//
// Input stream (s_axis_*): one request is a frame of four signed Q1.23 samples.
// Output stream (m_axis_*): one request per input frame, four mixed signed
// Q1.23 samples and one clip flag per output channel.
// Output m = sum over inputs j of sample j * gain(m, j), rounded half up to
// Q1.23 and clamped; gains are signed Q4.12, row m written by cfg_index m.
// Load gains through cfg_we/cfg_index/cfg_wdata only while the stream is idle; the block does not enforce it.
// A chain of one cell per input channel, each adding one product column, is
// followed by an output register that rounds and saturates.
// From accept to m_axis_tvalid a frame passes every cell register, then the output register.
// Throughput: one frame per cycle while m_axis_tready stays high; every cell and the output stage hold a
// frame each, so up to IN_CHANNELS + 1 frames are in flight.
// A stalled receiver holds the output; earlier stages keep filling until all
// are full, then s_axis_tready drops.
// Reset clears all gains (outputs silent) and empties the chain.
`timescale 1ns / 1ps
module audio_matrix_mixer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // sample_in0 [23:0], sample_in1 [47:24], sample_in2 [71:48], sample_in3 [95:72]
    input  logic [mmx_pkg::DATA_W-1:0]    s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // mix_out0 [23:0], mix_out1 [47:24], mix_out2 [71:48], mix_out3 [95:72]
    output logic [mmx_pkg::DATA_W-1:0]    m_axis_tdata,
    // clipped [3:0]
    output logic [mmx_pkg::NUM_OUT-1:0]   m_axis_tuser,
    input  logic                          cfg_we,
    input  logic [mmx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mmx_pkg::ROW_W-1:0]     cfg_wdata
);

    localparam int CELLS = mmx_pkg::IN_CHANNELS;

    mmx_pkg::row_t              gain_reg [mmx_pkg::NUM_OUT];
    logic                       valid_w  [CELLS+1];
    logic                       ready_w  [CELLS+1];
    mmx_pkg::frame_t            frame_w  [CELLS];
    mmx_pkg::acc_row_t          acc_w    [CELLS+1];
    mmx_pkg::gain_col_t         col_w    [CELLS];
    mmx_pkg::mix_t              mix_w;
    logic [mmx_pkg::NUM_OUT-1:0] clip_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int m = 0; m < mmx_pkg::NUM_OUT; m++) begin
                gain_reg[m] <= '0;
            end
        end else if (cfg_we) begin
            gain_reg[cfg_index] <= cfg_wdata;
        end
    end

    assign frame_w[0]    = mmx_pkg::frame_t'(s_axis_tdata);
    assign valid_w[0]    = s_axis_tvalid;
    assign s_axis_tready = ready_w[0];
    assign acc_w[0]      = '0;

    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        // gain column for this input; outputs past OUT_CHANNELS see zero gain
        for (genvar m = 0; m < mmx_pkg::NUM_OUT; m++) begin : g_col
            if (m < mmx_pkg::OUT_CHANNELS) begin : g_on
                assign col_w[j][m] = gain_reg[m][j*mmx_pkg::GAIN_W +: mmx_pkg::GAIN_W];
            end else begin : g_off
                assign col_w[j][m] = '0;
            end
        end

        if (j < CELLS - 1) begin : g_mid
            mmx_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .up_valid   (valid_w[j]),
                .up_ready   (ready_w[j]),
                .up_frame   (frame_w[j]),
                .up_acc     (acc_w[j]),
                .tap_sample (frame_w[j][j]),
                .tap_gains  (col_w[j]),
                .dn_valid   (valid_w[j+1]),
                .dn_ready   (ready_w[j+1]),
                .dn_frame   (frame_w[j+1]),
                .dn_acc     (acc_w[j+1])
            );
        end else begin : g_last
            mmx_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .up_valid   (valid_w[j]),
                .up_ready   (ready_w[j]),
                .up_frame   (frame_w[j]),
                .up_acc     (acc_w[j]),
                .tap_sample (frame_w[j][j]),
                .tap_gains  (col_w[j]),
                .dn_valid   (valid_w[j+1]),
                .dn_ready   (ready_w[j+1]),
                .dn_frame   (),
                .dn_acc     (acc_w[j+1])
            );
        end
    end

    mmx_sat u_sat (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .up_valid (valid_w[CELLS]),
        .up_ready (ready_w[CELLS]),
        .up_acc   (acc_w[CELLS]),
        .dn_valid (m_axis_tvalid),
        .dn_ready (m_axis_tready),
        .dn_mix   (mix_w),
        .dn_clip  (clip_w)
    );

    always_comb begin
        for (int m = 0; m < mmx_pkg::NUM_OUT; m++) begin
            m_axis_tdata[m*mmx_pkg::SAMPLE_W +: mmx_pkg::SAMPLE_W] = mix_w[m];
        end
    end

    assign m_axis_tuser = clip_w;

endmodule

[test/testbench.sv]
// Self-checking testbench for the four-by-four audio matrix mixer
`timescale 1ns / 1ps
module testbench;

    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_PHASES = 6;
    localparam int FRAMES_PER_PHASE = 242;
    localparam int REPORT_MAX = 10;
    localparam mmx_pkg::gain_t UNITY = 16'sh1000;
    localparam mmx_pkg::gain_t GAIN_MAX = 16'sh7FFF;
    localparam mmx_pkg::gain_t GAIN_MIN = 16'sh8000;

    typedef struct packed {
        mmx_pkg::mix_t               mix;
        logic [mmx_pkg::NUM_OUT-1:0] clip;
    } mixed_frame_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [mmx_pkg::DATA_W-1:0]    s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [mmx_pkg::DATA_W-1:0]    m_axis_tdata;
    logic [mmx_pkg::NUM_OUT-1:0]   m_axis_tuser;
    logic                          cfg_we = 1'b0;
    logic [mmx_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mmx_pkg::ROW_W-1:0]     cfg_wdata = '0;

    mmx_pkg::row_t   gain_rows [mmx_pkg::NUM_OUT];
    mmx_pkg::frame_t pending_frames [$];
    mixed_frame_t    expected_mix [$];

    int mismatches = 0;
    int frames_sent = 0;
    int frames_checked = 0;
    int clipped_seen = 0;
    int gain_settings = 0;
    int idle_cycles = 0;
    int src_gap = 0;
    int src_burst = 0;
    int sink_stall = 0;
    int sink_burst = 0;
    int sink_hold = 0;

    audio_matrix_mixer u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // products are exact in 40 bits, their sum in 42; rounding is half toward +inf
    function automatic mixed_frame_t mix_frame(mmx_pkg::frame_t smp);
        mixed_frame_t r;
        longint acc;
        longint rounded;
        mmx_pkg::gain_t g;
        r = '0;
        for (int m = 0; m < mmx_pkg::NUM_OUT; m++) begin
            if (m < mmx_pkg::OUT_CHANNELS) begin
                acc = 0;
                for (int j = 0; j < mmx_pkg::NUM_IN; j++) begin
                    if (j < mmx_pkg::IN_CHANNELS) begin
                        g = mmx_pkg::gain_t'(gain_rows[m][mmx_pkg::GAIN_W*j +: mmx_pkg::GAIN_W]);
                        acc += longint'(smp[j]) * longint'(g);
                    end
                end
                rounded = (acc + 2048) >>> mmx_pkg::FRAC_DROP;
                if (rounded > longint'(mmx_pkg::SAT_MAX)) begin
                    rounded = longint'(mmx_pkg::SAT_MAX);
                    r.clip[m] = 1'b1;
                end else if (rounded < longint'(mmx_pkg::SAT_MIN)) begin
                    rounded = longint'(mmx_pkg::SAT_MIN);
                    r.clip[m] = 1'b1;
                end
                r.mix[m] = mmx_pkg::sample_t'(rounded);
            end
        end
        return r;
    endfunction

    // random per-request wait, with occasional runs of back-to-back requests
    function automatic int draw_wait(inout int burst);
        int w;
        if (burst > 0) begin
            burst--;
            w = 0;
        end else begin
            w = $urandom_range(0, 5);
            if ($urandom_range(0, 19) == 0)
                burst = $urandom_range(10, 40);
        end
        return w;
    endfunction

    function automatic mmx_pkg::sample_t rand_sample();
        mmx_pkg::sample_t s;
        case ($urandom_range(0, 7))
            0: s = mmx_pkg::SAT_MAX;
            1: s = mmx_pkg::SAT_MIN;
            2: s = '0;
            3: s = mmx_pkg::sample_t'($urandom_range(0, 8192) - 4096);
            default: s = mmx_pkg::sample_t'($urandom);
        endcase
        return s;
    endfunction

    function automatic mmx_pkg::gain_t rand_gain(int mode);
        mmx_pkg::gain_t g;
        case (mode)
            0: g = mmx_pkg::gain_t'($urandom);
            1: g = mmx_pkg::gain_t'($urandom_range(0, 8192) - 4096);
            default: begin
                case ($urandom_range(0, 4))
                    0: g = GAIN_MAX;
                    1: g = GAIN_MIN;
                    2: g = '0;
                    3: g = UNITY;
                    default: g = mmx_pkg::gain_t'($urandom);
                endcase
            end
        endcase
        return g;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("mismatch @%0t frame %0d %s: expected %h, got %h",
                     $realtime, frames_checked, what, want, got);
    endtask

    task automatic send(mmx_pkg::sample_t s0, mmx_pkg::sample_t s1,
                        mmx_pkg::sample_t s2, mmx_pkg::sample_t s3);
        mmx_pkg::frame_t f;
        f[0] = s0;
        f[1] = s1;
        f[2] = s2;
        f[3] = s3;
        pending_frames.push_back(f);
    endtask

    task automatic set_gains(mmx_pkg::row_t rows [mmx_pkg::NUM_OUT]);
        for (int i = 0; i < mmx_pkg::NUM_OUT; i++) begin
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= mmx_pkg::CFG_IDX_W'(i);
            cfg_wdata <= rows[i];
            gain_rows[i] = rows[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
        gain_settings++;
    endtask

    task automatic wait_idle(int tail);
        do @(negedge aclk);
        while (pending_frames.size() != 0 || s_axis_tvalid || expected_mix.size() != 0);
        repeat (tail) @(posedge aclk);
    endtask

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            src_gap = 0;
        end else if (!(s_axis_tvalid && !s_axis_tready)) begin
            if (s_axis_tvalid) begin
                expected_mix.push_back(mix_frame(mmx_pkg::frame_t'(s_axis_tdata)));
                frames_sent++;
            end
            if (src_gap > 0) begin
                src_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (pending_frames.size() > 0) begin
                s_axis_tdata  <= pending_frames.pop_front();
                s_axis_tvalid <= 1'b1;
                src_gap = draw_wait(src_burst);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // sink side
    always @(posedge aclk) begin
        mixed_frame_t got;
        mixed_frame_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            sink_stall = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.mix  = mmx_pkg::mix_t'(m_axis_tdata);
                got.clip = m_axis_tuser;
                if (expected_mix.size() == 0) begin
                    note_mismatch("unexpected request", '0, got.clip);
                end else begin
                    want = expected_mix.pop_front();
                    for (int m = 0; m < mmx_pkg::NUM_OUT; m++)
                        if (got.mix[m] !== want.mix[m])
                            note_mismatch($sformatf("mix_out%0d", m), want.mix[m], got.mix[m]);
                    if (got.clip !== want.clip)
                        note_mismatch("clipped", want.clip, got.clip);
                    clipped_seen += $countones(want.clip);
                end
                frames_checked++;
                // long back-pressure so the pipeline fills and the input stalls
                if (frames_checked % 500 == 400)
                    sink_hold = 300;
                sink_stall = draw_wait(sink_burst);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                m_axis_tready <= 1'b0;
            end else if (sink_stall > 0) begin
                sink_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
                $display("testbench: errors");
                $finish;
            end
        end
    end

    initial begin
        mmx_pkg::row_t rows [mmx_pkg::NUM_OUT];
        int mode;
        for (int i = 0; i < mmx_pkg::NUM_OUT; i++)
            gain_rows[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // gains still at reset: everything silent
        send(mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX);
        send(mmx_pkg::SAT_MIN, mmx_pkg::SAT_MIN, mmx_pkg::SAT_MIN, mmx_pkg::SAT_MIN);
        send(mmx_pkg::SAT_MAX, mmx_pkg::SAT_MIN, '0, 24'sh555555);
        wait_idle(6);

        // identity routing
        for (int m = 0; m < mmx_pkg::NUM_OUT; m++) begin
            rows[m] = '0;
            rows[m][mmx_pkg::GAIN_W*m +: mmx_pkg::GAIN_W] = UNITY;
        end
        set_gains(rows);
        send(mmx_pkg::SAT_MAX, mmx_pkg::SAT_MIN, '0, 24'sh000001);
        send(24'shAAAAAA, 24'sh555555, -24'sd1, mmx_pkg::SAT_MIN);
        send(mmx_pkg::SAT_MIN, mmx_pkg::SAT_MAX, 24'sh000001, '0);
        send(-24'sd1, -24'sd1, mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX);
        wait_idle(6);

        // largest positive gain everywhere
        for (int m = 0; m < mmx_pkg::NUM_OUT; m++)
            rows[m] = {mmx_pkg::NUM_IN{GAIN_MAX}};
        set_gains(rows);
        send(mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX);
        send(mmx_pkg::SAT_MIN, mmx_pkg::SAT_MIN, mmx_pkg::SAT_MIN, mmx_pkg::SAT_MIN);
        send('0, '0, '0, '0);
        send(24'sd1, -24'sd1, 24'sd1, -24'sd1);
        wait_idle(6);

        // most negative gain everywhere
        for (int m = 0; m < mmx_pkg::NUM_OUT; m++)
            rows[m] = {mmx_pkg::NUM_IN{GAIN_MIN}};
        set_gains(rows);
        send(mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX);
        send(mmx_pkg::SAT_MIN, mmx_pkg::SAT_MIN, mmx_pkg::SAT_MIN, mmx_pkg::SAT_MIN);
        send(mmx_pkg::SAT_MIN, '0, '0, '0);
        send(24'sd1, '0, '0, '0);
        wait_idle(6);

        // rounding: tiny gains put the half-LSB cases right on the boundary
        rows[0] = {48'h0, 16'h0001};
        rows[1] = {48'h0, 16'hFFFF};
        rows[2] = {GAIN_MAX, 16'sh0800, 16'shF000, UNITY};
        rows[3] = '0;
        set_gains(rows);
        send(24'sd2048, 24'sd2048, 24'sd2048, 24'sd2048);
        send(-24'sd2048, -24'sd2048, -24'sd2048, -24'sd2048);
        send(24'sd2047, 24'sd1, -24'sd1, 24'sd3);
        send(-24'sd2049, 24'sd6144, -24'sd6144, 24'sd1);
        send(24'sd6144, mmx_pkg::SAT_MAX, mmx_pkg::SAT_MIN, mmx_pkg::SAT_MAX);
        send(mmx_pkg::SAT_MAX, mmx_pkg::SAT_MAX, '0, '0);
        wait_idle(6);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            mode = p % 3;
            for (int m = 0; m < mmx_pkg::NUM_OUT; m++)
                for (int j = 0; j < mmx_pkg::NUM_IN; j++)
                    rows[m][mmx_pkg::GAIN_W*j +: mmx_pkg::GAIN_W] = rand_gain(mode);
            set_gains(rows);
            for (int k = 0; k < FRAMES_PER_PHASE; k++)
                send(rand_sample(), rand_sample(), rand_sample(), rand_sample());
            wait_idle(6);
        end

        wait_idle(10);
        $display("summary: %0d frames mixed under %0d gain settings, %0d outputs saturated",
                 frames_checked, gain_settings, clipped_seen);
        $display("summary: %0d mismatches", mismatches);
        if (mismatches == 0 && expected_mix.size() == 0 && frames_checked == frames_sent) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
